// ===== rtl/fsbt_pkg.sv =====
// Shared types and codes of the free space block table.
`timescale 1ns / 1ps
package fsbt_pkg;

    localparam logic [2:0] OP_BEGIN    = 3'd0;
    localparam logic [2:0] OP_APPEND   = 3'd1;
    localparam logic [2:0] OP_REQUEST  = 3'd2;
    localparam logic [2:0] OP_SET      = 3'd3;
    localparam logic [2:0] OP_TAKE     = 3'd4;
    localparam logic [2:0] OP_TRUNCATE = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXTEND    = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [7:0] MISS_SAT = 8'd255;

    typedef struct packed {
        logic [31:0] block;
        logic [15:0] free;
        logic [7:0]  misses;
        logic [15:0] spare;
        logic        live;
    } entry_t;

    typedef struct packed {
        logic load;
        logic init;
        logic rd;
        logic ev;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic scan;
        logic scan_end;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/fsbt_in_if.sv =====
// Input channel of the free space block table.
`timescale 1ns / 1ps
interface fsbt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] block_number;
    logic [15:0] byte_count;
    logic [15:0] free_slots;
    logic [31:0] lowest_block;

    modport source (output valid, opcode, block_number, byte_count, free_slots,
                    lowest_block, input ready);
    modport sink (input valid, opcode, block_number, byte_count, free_slots,
                  lowest_block, output ready);
endinterface

// ===== rtl/fsbt_out_if.sv =====
// Result channel of the free space block table.
`timescale 1ns / 1ps
interface fsbt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_block;
    logic [31:0] total_free;

    modport source (output valid, status, result_block, total_free, input ready);
    modport sink (input valid, status, result_block, total_free, output ready);
endinterface

// ===== rtl/fsbt_datapath.sv =====
// Datapath of the free space block table: entry memory, hints, sums and result register.
`timescale 1ns / 1ps
module fsbt_datapath #(
    parameter int ENTRIES            = 1024,
    parameter int HINTS              = 8,
    parameter int MAX_TUPLE_BYTES    = 8160,
    parameter int BLOB_BYTES         = 8000,
    parameter int LINE_POINTER_BYTES = 4,
    parameter int MISS_LIMIT         = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsbt_pkg::cmd_t       cmd,
    output fsbt_pkg::stat_t      st,
    input  logic [2:0]           opcode,
    input  logic [31:0]          block_number,
    input  logic [15:0]          byte_count,
    input  logic [15:0]          free_slots,
    input  logic [31:0]          lowest_block,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [31:0]          result_block,
    output logic [31:0]          total_free
);

    localparam int AW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int HIW = $clog2(HINTS);

    fsbt_pkg::entry_t mem [ENTRIES];
    fsbt_pkg::entry_t rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    fsbt_pkg::entry_t mem_wd;

    logic [2:0]  op_reg;
    logic [31:0] blk_reg;
    logic [15:0] bytes_reg;
    logic [15:0] slots_reg;
    logic [31:0] limit_reg;
    logic [2:0]  op_next;
    logic [31:0] blk_next;
    logic [15:0] bytes_next;
    logic [15:0] slots_next;
    logic [31:0] limit_next;

    logic [CW-1:0]  p_reg, p_next;
    logic [HIW-1:0] idx_reg, idx_next;
    logic           found_reg, found_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  next_pos_reg, next_pos_next;
    logic [CW-1:0]  hint_pos_reg [HINTS];
    logic [CW-1:0]  hint_pos_next [HINTS];
    logic [15:0]    hint_bytes_reg [HINTS];
    logic [15:0]    hint_bytes_next [HINTS];
    logic [15:0]    least_reg, least_next;
    logic [15:0]    largest_reg, largest_next;
    logic [31:0]    free_total_reg, free_total_next;
    logic [31:0]    rel_reg, rel_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] result_reg, result_next;
    logic [31:0] total_reg, total_next;

    logic [31:0]    thr_hi [HINTS];
    logic [31:0]    thr_lo [HINTS];
    logic [HIW-1:0] sel_idx;
    logic           oversize;
    logic           ev_hit;

    for (genvar g = 0; g < HINTS; g++) begin : g_thr
        localparam int THR_HI = MAX_TUPLE_BYTES / (HINTS - g);
        localparam int THR_LO = (MAX_TUPLE_BYTES / HINTS) * g;
        assign thr_hi[g] = 32'(THR_HI);
        assign thr_lo[g] = 32'(THR_LO);
    end

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] v);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, v};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] floor_sub(input logic [31:0] a, input logic [31:0] v);
        return (a < v) ? 32'd0 : a - v;
    endfunction

    assign oversize = {16'd0, bytes_reg} > 32'(MAX_TUPLE_BYTES);

    always_comb
    begin
        sel_idx = HIW'(HINTS - 1);
        for (int i = HINTS - 1; i >= 0; i--)
        begin
            if (bytes_reg <= hint_bytes_reg[i] || hint_pos_reg[i] == '0)
            begin
                sel_idx = HIW'(i);
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            fsbt_pkg::OP_REQUEST:
                ev_hit = rd_data_reg.live && rd_data_reg.block >= limit_reg
                         && rd_data_reg.free > bytes_reg;
            fsbt_pkg::OP_SET:  ev_hit = rd_data_reg.block == blk_reg;
            fsbt_pkg::OP_TAKE: ev_hit = 1'b1;
            default:           ev_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        st.scan = (op_reg == fsbt_pkg::OP_REQUEST && !oversize)
                  || op_reg == fsbt_pkg::OP_SET || op_reg == fsbt_pkg::OP_TAKE
                  || op_reg == fsbt_pkg::OP_TRUNCATE;
        st.scan_end = p_reg >= count_reg;
        st.hit      = ev_hit;
        st.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        fsbt_pkg::entry_t e;
        logic [16:0] take;
        logic [15:0] avail;
        logic [31:0] ft;
        e = rd_data_reg;
        take = '0;
        avail = '0;
        ft = free_total_reg;

        op_next = op_reg;
        blk_next = blk_reg;
        bytes_next = bytes_reg;
        slots_next = slots_reg;
        limit_next = limit_reg;
        p_next = p_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        count_next = count_reg;
        next_pos_next = next_pos_reg;
        hint_pos_next = hint_pos_reg;
        hint_bytes_next = hint_bytes_reg;
        least_next = least_reg;
        largest_next = largest_reg;
        rel_next = rel_reg;
        status_next = status_reg;
        result_next = result_reg;
        total_next = total_reg;
        mem_we = 1'b0;
        mem_wa = p_reg[AW-1:0];
        mem_wd = rd_data_reg;

        if (cmd.load)
        begin
            op_next = opcode;
            blk_next = block_number;
            bytes_next = byte_count;
            slots_next = free_slots;
            limit_next = lowest_block;
        end

        if (cmd.init)
        begin
            found_next = 1'b0;
            case (op_reg)
                fsbt_pkg::OP_REQUEST:
                begin
                    idx_next = sel_idx;
                    p_next = (hint_pos_reg[sel_idx] == '0) ? next_pos_reg
                                                            : hint_pos_reg[sel_idx];
                end
                fsbt_pkg::OP_TAKE: p_next = next_pos_reg;
                default:           p_next = '0;
            endcase
        end

        if (cmd.ev)
        begin
            case (op_reg)
                fsbt_pkg::OP_REQUEST:
                begin
                    if (!e.live)
                    begin
                        if (next_pos_reg == p_reg)
                        begin
                            next_pos_next = next_pos_reg + 1'b1;
                        end
                        p_next = p_reg + 1'b1;
                    end
                    else if (ev_hit)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        if (e.block >= limit_reg)
                        begin
                            if (32'(e.misses) > 32'(MISS_LIMIT))
                            begin
                                e.live = 1'b0;
                            end
                            if (e.misses < fsbt_pkg::MISS_SAT)
                            begin
                                e.misses = e.misses + 1'b1;
                            end
                        end
                        if (e.free < least_reg)
                        begin
                            e.live = 1'b0;
                        end
                        mem_we = 1'b1;
                        mem_wd = e;
                        p_next = p_reg + 1'b1;
                    end
                end
                fsbt_pkg::OP_SET:
                begin
                    if (ev_hit)
                    begin
                        found_next = 1'b1;
                        if (bytes_reg < least_reg)
                        begin
                            e.live = 1'b0;
                        end
                        ft = sat_add(floor_sub(free_total_reg, {16'd0, e.free}),
                                     {16'd0, bytes_reg});
                        e.free = bytes_reg;
                        mem_we = 1'b1;
                        mem_wd = e;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
                fsbt_pkg::OP_TAKE:
                begin
                    found_next = 1'b1;
                    e.live = 1'b0;
                    mem_we = 1'b1;
                    mem_wd = e;
                    next_pos_next = next_pos_reg + 1'b1;
                end
                fsbt_pkg::OP_TRUNCATE:
                begin
                    if (e.block >= blk_reg)
                    begin
                        e.live = 1'b0;
                        ft = floor_sub(free_total_reg, {16'd0, e.free});
                        e.free = '0;
                        mem_we = 1'b1;
                        mem_wd = e;
                    end
                    p_next = p_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.fin)
        begin
            status_next = fsbt_pkg::ST_OK;
            result_next = '0;
            case (op_reg)
                fsbt_pkg::OP_BEGIN:
                begin
                    count_next = '0;
                    next_pos_next = '0;
                    for (int h = 0; h < HINTS; h++)
                    begin
                        hint_pos_next[h] = '0;
                        hint_bytes_next[h] = '0;
                    end
                    hint_bytes_next[0] = 16'(BLOB_BYTES);
                    least_next = 16'(MAX_TUPLE_BYTES);
                    largest_next = '0;
                    ft = '0;
                    rel_next = blk_reg;
                    result_next = blk_reg;
                end
                fsbt_pkg::OP_APPEND:
                begin
                    if (32'(count_reg) >= 32'(ENTRIES))
                    begin
                        status_next = fsbt_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = count_reg[AW-1:0];
                        mem_wd.block = blk_reg;
                        mem_wd.free = bytes_reg;
                        mem_wd.misses = '0;
                        mem_wd.spare = slots_reg;
                        mem_wd.live = 1'b1;
                        count_next = count_reg + 1'b1;
                        ft = sat_add(free_total_reg, {16'd0, bytes_reg});
                    end
                end
                fsbt_pkg::OP_REQUEST:
                begin
                    if (oversize)
                    begin
                        status_next = fsbt_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        if (least_reg > bytes_reg)
                        begin
                            least_next = bytes_reg;
                        end
                        if (largest_reg < bytes_reg)
                        begin
                            largest_next = bytes_reg;
                        end
                        if (!found_reg)
                        begin
                            status_next = fsbt_pkg::ST_EXTEND;
                            result_next = rel_reg;
                        end
                        else
                        begin
                            take = {1'b0, bytes_reg};
                            if (e.spare == '0)
                            begin
                                take = take + 17'(LINE_POINTER_BYTES);
                            end
                            else
                            begin
                                e.spare = e.spare - 1'b1;
                            end
                            if (take > {1'b0, e.free})
                            begin
                                take = {1'b0, e.free};
                            end
                            avail = e.free - take[15:0];
                            e.misses = '0;
                            e.free = avail;
                            if (32'(bytes_reg) >= 32'(BLOB_BYTES))
                            begin
                                e.live = 1'b0;
                            end
                            mem_we = 1'b1;
                            mem_wd = e;
                            ft = floor_sub(free_total_reg, {15'd0, take});
                            result_next = e.block;
                            if (limit_reg <= 32'(hint_pos_reg[idx_reg]))
                            begin
                                if (hint_bytes_reg[idx_reg] > bytes_reg
                                    && hint_pos_reg[HINTS-1] == '0)
                                begin
                                    for (int h = HINTS - 1; h > 0; h--)
                                    begin
                                        if (HIW'(h) > idx_reg)
                                        begin
                                            hint_pos_next[h] = hint_pos_reg[h-1];
                                            hint_bytes_next[h] = hint_bytes_reg[h-1];
                                        end
                                    end
                                    hint_pos_next[idx_reg] = p_reg;
                                    hint_bytes_next[idx_reg] = bytes_reg;
                                end
                                else if (thr_hi[idx_reg] > {16'd0, avail}
                                         && {16'd0, avail} > thr_lo[idx_reg])
                                begin
                                    hint_pos_next[idx_reg] = p_reg;
                                    hint_bytes_next[idx_reg] = avail;
                                end
                                else
                                begin
                                    hint_pos_next[idx_reg] = p_reg;
                                end
                            end
                        end
                    end
                end
                fsbt_pkg::OP_SET:
                begin
                    status_next = found_reg ? fsbt_pkg::ST_OK : fsbt_pkg::ST_NOT_FOUND;
                    result_next = found_reg ? blk_reg : 32'd0;
                end
                fsbt_pkg::OP_TAKE:
                begin
                    status_next = found_reg ? fsbt_pkg::ST_OK : fsbt_pkg::ST_EXTEND;
                    result_next = found_reg ? rd_data_reg.block : rel_reg;
                end
                fsbt_pkg::OP_TRUNCATE:
                begin
                    rel_next = blk_reg;
                    result_next = blk_reg;
                end
                default:
                begin
                end
            endcase
            total_next = ft;
        end
        free_total_next = ft;

        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[p_reg[AW-1:0]];
        end
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        op_reg <= op_next;
        blk_reg <= blk_next;
        bytes_reg <= bytes_next;
        slots_reg <= slots_next;
        limit_reg <= limit_next;
        p_reg <= p_next;
        idx_reg <= idx_next;
        status_reg <= status_next;
        result_reg <= result_next;
        total_reg <= total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            count_reg <= '0;
            next_pos_reg <= '0;
            for (int h = 0; h < HINTS; h++)
            begin
                hint_pos_reg[h] <= '0;
                hint_bytes_reg[h] <= (h == 0) ? 16'(BLOB_BYTES) : 16'd0;
            end
            least_reg <= 16'(MAX_TUPLE_BYTES);
            largest_reg <= '0;
            free_total_reg <= '0;
            rel_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
            count_reg <= count_next;
            next_pos_reg <= next_pos_next;
            hint_pos_reg <= hint_pos_next;
            hint_bytes_reg <= hint_bytes_next;
            least_reg <= least_next;
            largest_reg <= largest_next;
            free_total_reg <= free_total_next;
            rel_reg <= rel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign result_block = result_reg;
    assign total_free = total_reg;

endmodule

// ===== rtl/fsbt_ctrl.sv =====
// Controller state machine of the free space block table.
`timescale 1ns / 1ps
module fsbt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fsbt_pkg::stat_t st,
    output fsbt_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init = 1'b1;
                state_next = st.scan ? S_RD : S_FIN;
            end
            S_RD:
            begin
                if (st.scan_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                cmd.ev = 1'b1;
                state_next = st.hit ? S_FIN : S_RD;
            end
            S_FIN:
            begin
                if (st.out_free)
                begin
                    cmd.fin = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/free_space_block_table_core.sv =====
// Top level of the free space block table.
//
// op_chan takes one operation beat at a time; res_chan returns exactly one
// result beat for each, in order. Both use valid/ready handshakes.
// Each entry visited is read into a register, then updated. Begin load,
// append, unused opcodes and an oversized request visit none; take next
// visits one (none when the table is used up); set space stops at the
// first match; truncate visits every table entry; request visits from its
// start hint to the first fit.
// The next beat is accepted only after the controller returns to idle
// once the previous result is registered, so operations do not overlap.
// While the receiver stalls, a new operation may run up to its result and
// then holds until the output register drains.
// Reset clears counts, hints, bounds and sums at once; the entry memory is
// not cleared, as only entries below the count are ever read.
`timescale 1ns / 1ps
module free_space_block_table_core #(
    parameter int ENTRIES            = 1024,
    parameter int HINTS              = 8,
    parameter int MAX_TUPLE_BYTES    = 8160,
    parameter int BLOB_BYTES         = 8000,
    parameter int LINE_POINTER_BYTES = 4,
    parameter int MISS_LIMIT         = 128
) (
    input logic      clk,
    input logic      rst_n,
    fsbt_in_if.sink  op_chan,
    fsbt_out_if.source res_chan
);

    fsbt_pkg::cmd_t  cmd;
    fsbt_pkg::stat_t st;

    fsbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (op_chan.valid),
        .in_ready (op_chan.ready),
        .st       (st),
        .cmd      (cmd)
    );

    fsbt_datapath #(
        .ENTRIES            (ENTRIES),
        .HINTS              (HINTS),
        .MAX_TUPLE_BYTES    (MAX_TUPLE_BYTES),
        .BLOB_BYTES         (BLOB_BYTES),
        .LINE_POINTER_BYTES (LINE_POINTER_BYTES),
        .MISS_LIMIT         (MISS_LIMIT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .opcode       (op_chan.opcode),
        .block_number (op_chan.block_number),
        .byte_count   (op_chan.byte_count),
        .free_slots   (op_chan.free_slots),
        .lowest_block (op_chan.lowest_block),
        .out_valid    (res_chan.valid),
        .out_ready    (res_chan.ready),
        .status       (res_chan.status),
        .result_block (res_chan.result_block),
        .total_free   (res_chan.total_free)
    );

endmodule

// ===== tb/fsbt_tb_if.sv =====
// Testbench-side copies of the channel interfaces are not needed; this file holds the driver and result beat types.
`timescale 1ns / 1ps
package fsbt_tb_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] block_number;
        logic [15:0] byte_count;
        logic [15:0] free_slots;
        logic [31:0] lowest_block;
    } op_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_block;
        logic [31:0] total_free;
    } res_beat_t;

endpackage

// ===== tb/free_space_block_table_core_tb.sv =====
// Testbench of the free space block table: queued directed and random operations, predicted results, beat checks.
`timescale 1ns / 1ps
module free_space_block_table_core_tb;

    localparam int ENTRIES = 1024;
    localparam int HINTS = 8;
    localparam int MAX_TUPLE = 8160;
    localparam int BLOB = 8000;
    localparam int LP_BYTES = 4;
    localparam int MISS_LIMIT = 128;

    logic clk;
    logic rst_n;

    fsbt_in_if op_chan ();
    fsbt_out_if res_chan ();

    free_space_block_table_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .op_chan(op_chan.sink),
        .res_chan(res_chan.source)
    );

    logic [31:0] tbl_block [ENTRIES];
    logic [15:0] tbl_free [ENTRIES];
    logic [7:0]  tbl_misses [ENTRIES];
    logic [15:0] tbl_spare [ENTRIES];
    logic        tbl_live [ENTRIES];
    int unsigned tbl_count;
    int unsigned take_pos;
    int unsigned hint_pos [HINTS];
    int unsigned hint_size [HINTS];
    int unsigned least_req;
    int unsigned largest_req;
    logic [31:0] free_sum;
    logic [31:0] rel_blocks;

    fsbt_tb_pkg::op_beat_t  pending_ops [$];
    fsbt_tb_pkg::res_beat_t expected_results [$];
    int errors;
    int idle_pct;
    bit hold_sink;
    bit hold_req;
    bit stim_done;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        end
    endtask

    function automatic void add_free(input logic [31:0] v);
        free_sum = (free_sum > 32'hFFFF_FFFF - v) ? 32'hFFFF_FFFF : free_sum + v;
    endfunction

    function automatic void sub_free(input logic [31:0] v);
        free_sum = (free_sum < v) ? 32'd0 : free_sum - v;
    endfunction

    function automatic void clear_table();
        tbl_count = 0;
        take_pos = 0;
        for (int h = 0; h < HINTS; h++)
        begin
            hint_pos[h] = 0;
            hint_size[h] = 0;
        end
        hint_size[0] = BLOB;
        least_req = MAX_TUPLE;
        largest_req = 0;
        free_sum = 0;
    endfunction

    function automatic fsbt_tb_pkg::res_beat_t serve_request(input int unsigned req,
                                                             input logic [31:0] lim);
        fsbt_tb_pkg::res_beat_t r;
        int unsigned idx;
        int unsigned p;
        int unsigned take;
        int unsigned avail;
        bit hit;
        begin
            r = '0;
            hit = 0;
            if (req > MAX_TUPLE)
            begin
                r.status = fsbt_pkg::ST_TOO_LARGE;
                return r;
            end
            for (idx = 0; idx < HINTS; idx++)
            begin
                if (req <= hint_size[idx]) break;
                if (hint_pos[idx] == 0) break;
            end
            if (idx == HINTS) idx = HINTS - 1;
            p = hint_pos[idx];
            if (p == 0) p = take_pos;
            while (p < tbl_count && p < ENTRIES)
            begin
                if (!tbl_live[p])
                begin
                    if (take_pos == p) take_pos++;
                    p++;
                    continue;
                end
                if (tbl_block[p] >= lim)
                begin
                    if (tbl_free[p] > req)
                    begin
                        hit = 1;
                        break;
                    end
                    if (tbl_misses[p] > MISS_LIMIT) tbl_live[p] = 0;
                    if (tbl_misses[p] < fsbt_pkg::MISS_SAT) tbl_misses[p]++;
                end
                if (tbl_free[p] < least_req) tbl_live[p] = 0;
                p++;
            end
            if (least_req > req) least_req = req;
            if (largest_req < req) largest_req = req;
            if (!hit)
            begin
                r.status = fsbt_pkg::ST_EXTEND;
                r.result_block = rel_blocks;
                return r;
            end
            take = req;
            avail = tbl_free[p];
            if (tbl_spare[p] == 0) take += LP_BYTES;
            else tbl_spare[p]--;
            if (take > avail) take = avail;
            tbl_misses[p] = 0;
            avail -= take;
            tbl_free[p] = avail[15:0];
            if (req >= BLOB) tbl_live[p] = 0;
            sub_free(take);
            if (lim <= hint_pos[idx])
            begin
                if (hint_size[idx] > req && hint_pos[HINTS-1] == 0)
                begin
                    for (int h = HINTS - 1; h > idx; h--)
                    begin
                        hint_pos[h] = hint_pos[h-1];
                        hint_size[h] = hint_size[h-1];
                    end
                    hint_pos[idx] = p;
                    hint_size[idx] = req;
                end
                else if (MAX_TUPLE / (HINTS - idx) > avail &&
                         avail > (MAX_TUPLE / HINTS) * idx)
                begin
                    hint_pos[idx] = p;
                    hint_size[idx] = avail;
                end
                else
                    hint_pos[idx] = p;
            end
            r.status = fsbt_pkg::ST_OK;
            r.result_block = tbl_block[p];
            return r;
        end
    endfunction

    function automatic fsbt_tb_pkg::res_beat_t predict_result(input fsbt_tb_pkg::op_beat_t op);
        fsbt_tb_pkg::res_beat_t r;
        int unsigned p;
        begin
            r = '0;
            case (op.opcode)
                fsbt_pkg::OP_BEGIN:
                begin
                    clear_table();
                    rel_blocks = op.block_number;
                    r.result_block = op.block_number;
                end
                fsbt_pkg::OP_APPEND:
                begin
                    if (tbl_count >= ENTRIES)
                        r.status = fsbt_pkg::ST_TOO_LARGE;
                    else
                    begin
                        p = tbl_count;
                        tbl_block[p] = op.block_number;
                        tbl_free[p] = op.byte_count;
                        tbl_spare[p] = op.free_slots;
                        tbl_misses[p] = 0;
                        tbl_live[p] = 1;
                        tbl_count++;
                        add_free(op.byte_count);
                    end
                end
                fsbt_pkg::OP_REQUEST:
                    r = serve_request(op.byte_count, op.lowest_block);
                fsbt_pkg::OP_SET:
                begin
                    r.status = fsbt_pkg::ST_NOT_FOUND;
                    for (p = 0; p < tbl_count; p++)
                    begin
                        if (tbl_block[p] == op.block_number)
                        begin
                            if (op.byte_count < least_req) tbl_live[p] = 0;
                            sub_free(tbl_free[p]);
                            tbl_free[p] = op.byte_count;
                            add_free(op.byte_count);
                            r.status = fsbt_pkg::ST_OK;
                            r.result_block = op.block_number;
                            break;
                        end
                    end
                end
                fsbt_pkg::OP_TAKE:
                begin
                    if (take_pos < tbl_count)
                    begin
                        r.result_block = tbl_block[take_pos];
                        tbl_live[take_pos] = 0;
                        take_pos++;
                    end
                    else
                    begin
                        r.status = fsbt_pkg::ST_EXTEND;
                        r.result_block = rel_blocks;
                    end
                end
                fsbt_pkg::OP_TRUNCATE:
                begin
                    rel_blocks = op.block_number;
                    for (p = 0; p < tbl_count; p++)
                    begin
                        if (tbl_block[p] >= op.block_number)
                        begin
                            tbl_live[p] = 0;
                            sub_free(tbl_free[p]);
                            tbl_free[p] = 0;
                        end
                    end
                    r.result_block = op.block_number;
                end
                default: ;
            endcase
            r.total_free = free_sum;
            return r;
        end
    endfunction

    function automatic fsbt_tb_pkg::op_beat_t make_op(input logic [2:0] code,
                                                      input logic [31:0] blk,
                                                      input logic [15:0] bytes,
                                                      input logic [15:0] slots,
                                                      input logic [31:0] lim);
        fsbt_tb_pkg::op_beat_t o;
        begin
            o.opcode = code;
            o.block_number = blk;
            o.byte_count = bytes;
            o.free_slots = slots;
            o.lowest_block = lim;
            return o;
        end
    endfunction

    function automatic logic [15:0] rand_bytes();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(8000, 8200));
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        return $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 300));
    endfunction

    function automatic fsbt_tb_pkg::op_beat_t rand_op(input int unsigned base);
        logic [2:0] code;
        begin
            case ($urandom_range(0, 19))
                0: code = 3'($urandom_range(6, 7));
                1: code = fsbt_pkg::OP_TRUNCATE;
                2, 3: code = fsbt_pkg::OP_SET;
                4, 5: code = fsbt_pkg::OP_TAKE;
                6, 7, 8, 9, 10: code = fsbt_pkg::OP_APPEND;
                default: code = fsbt_pkg::OP_REQUEST;
            endcase
            return make_op(code,
                           code == fsbt_pkg::OP_SET ? base - 32'($urandom_range(0, 40)) :
                           code == fsbt_pkg::OP_APPEND ? base + 32'($urandom_range(0, 3)) :
                           code == fsbt_pkg::OP_TRUNCATE ? base + 32'($urandom_range(0, 50)) :
                           rand_word(),
                           rand_bytes(), 16'($urandom_range(0, 3) == 0 ? $urandom : 0),
                           $urandom_range(0, 3) == 0 ? 32'($urandom) :
                           32'($urandom_range(0, base + 10)));
        end
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        int unsigned base;
        fsbt_tb_pkg::op_beat_t o;
        rst_n = 1'b0;
        errors = 0;
        idle_pct = 31;
        hold_sink = 0;
        hold_req = 0;
        stim_done = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_block[i] = '0;
            tbl_free[i] = '0;
            tbl_misses[i] = '0;
            tbl_spare[i] = '0;
            tbl_live[i] = 1'b0;
        end
        clear_table();
        rel_blocks = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        pending_ops.push_back(make_op(fsbt_pkg::OP_TAKE, 0, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 100, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_BEGIN, 32'hFFFF_FFFE, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 0, 16'hFFFF, 16'hFFFF, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 5, 16'hFFFF, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 32'hFFFF_FFFE, 300, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 2, 8100, 1, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 16'hFFFF, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 8161, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 8160, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 8000, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 0, 0, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 10, 0, 3));
        pending_ops.push_back(make_op(fsbt_pkg::OP_SET, 5, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_SET, 77, 5, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_TAKE, 0, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_TRUNCATE, 3, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_TRUNCATE, 32'hFFFF_FFFE, 0, 0, 0));
        pending_ops.push_back(make_op(3'd6, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(3'd7, 0, 0, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_BEGIN, 0, 0, 0, 0));
        for (int i = 0; i < 20; i++)
            pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 16'(10 + i), 0, 0));
        for (int i = 0; i < 10; i++)
            pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 32'(i), 50, 0, 0));
        for (int i = 0; i < 140; i++)
            pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 60, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_BEGIN, 100, 0, 0, 0));
        for (int i = 0; i < ENTRIES + 2; i++)
            pending_ops.push_back(make_op(fsbt_pkg::OP_APPEND, 32'(i), 16'hFFFF, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_REQUEST, 0, 10, 0, 0));
        pending_ops.push_back(make_op(fsbt_pkg::OP_TRUNCATE, 0, 0, 0, 0));
        wait (pending_ops.size() == 0);

        for (int seq = 0; seq < 8; seq++)
        begin
            base = $urandom_range(0, 200);
            pending_ops.push_back(make_op(fsbt_pkg::OP_BEGIN, rand_word(), 0, 0, 0));
            for (int i = 0; i < 36; i++)
            begin
                o = rand_op(base);
                if (o.opcode == fsbt_pkg::OP_APPEND) base = o.block_number;
                pending_ops.push_back(o);
            end
            if (seq == 2)
                hold_req = 1;
            if (seq == 3)
            begin
                wait (pending_ops.size() == 0 && !op_chan.valid
                      && expected_results.size() == 0);
                idle_pct = 0;
            end
            if (seq == 6)
                idle_pct = 31;
            wait (pending_ops.size() < 8);
        end
        wait (pending_ops.size() == 0);
        stim_done = 1;
    end

    initial
    begin
        wait (hold_req);
        hold_sink = 1;
        repeat (300) @(posedge clk);
        hold_sink = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_chan.valid <= 1'b0;
            op_chan.opcode <= '0;
            op_chan.block_number <= '0;
            op_chan.byte_count <= '0;
            op_chan.free_slots <= '0;
            op_chan.lowest_block <= '0;
        end
        else
        begin
            if (op_chan.valid && op_chan.ready)
                expected_results.push_back(predict_result({op_chan.opcode,
                    op_chan.block_number, op_chan.byte_count, op_chan.free_slots,
                    op_chan.lowest_block}));
            if (!op_chan.valid || op_chan.ready)
            begin
                if (pending_ops.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    fsbt_tb_pkg::op_beat_t o;
                    o = pending_ops.pop_front();
                    op_chan.valid <= 1'b1;
                    op_chan.opcode <= o.opcode;
                    op_chan.block_number <= o.block_number;
                    op_chan.byte_count <= o.byte_count;
                    op_chan.free_slots <= o.free_slots;
                    op_chan.lowest_block <= o.lowest_block;
                end
                else
                    op_chan.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_chan.ready <= 1'b0;
        else
        begin
            if (res_chan.valid && res_chan.ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected beat", res_chan.result_block, 32'd0);
                else
                begin
                    fsbt_tb_pkg::res_beat_t w;
                    w = expected_results.pop_front();
                    if (res_chan.status !== w.status)
                        report("status", res_chan.status, w.status);
                    if (res_chan.result_block !== w.result_block)
                        report("result_block", res_chan.result_block, w.result_block);
                    if (res_chan.total_free !== w.total_free)
                        report("total_free", res_chan.total_free, w.total_free);
                end
            end
            res_chan.ready <= !hold_sink && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    initial
    begin
        wait (stim_done);
        wait (expected_results.size() == 0 && !op_chan.valid);
        repeat (2200) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fsbt_pkg.sv
rtl/fsbt_in_if.sv
rtl/fsbt_out_if.sv
rtl/fsbt_datapath.sv
rtl/fsbt_ctrl.sv
rtl/free_space_block_table_core.sv
tb/fsbt_tb_if.sv
tb/free_space_block_table_core_tb.sv
